// File: rtl/hpb_pkg.sv
// Shared types, widths and constants for the hydrogen pair placement pipeline.
package hpb_pkg;

   localparam int COORD_W   = 28;   // coordinate width
   localparam int UNIT_BITS = 28;   // fraction bits of a unit vector
   localparam int SCALE_W   = 18;   // scale register width
   localparam int NV_W      = 31;   // normalizer input component width
   localparam int MAG_W     = 31;   // magnitude of a normalizer component
   localparam int SQ_W      = 61;   // one squared magnitude
   localparam int SUM_W     = 62;   // squared length
   localparam int K_W       = 5;    // pair shift count, 0 to 30
   localparam int SH_W      = 7;    // numerator shift amount
   localparam int ROOT_W    = 31;   // integer square root
   localparam int SQ_REM_W  = 34;   // square root partial remainder
   localparam int NUM_W     = 89;   // shifted numerator
   localparam int QUO_W     = 29;   // quotient bits
   localparam int DREM_W    = 32;   // divider partial remainder
   localparam int UNIT_W    = 30;   // signed unit vector component
   localparam int CR_W      = 61;   // cross product difference
   localparam int PROD_W    = 60;   // unit times unit
   localparam int P_W       = 33;   // rounded cross component
   localparam int ALONG_W   = 49;   // scale times unit
   localparam int ACROSS_W  = 52;   // scale times cross component
   localparam int BASE_W    = 58;   // center plus bisector term
   localparam int TOT_W     = 59;   // final unrounded sum

   localparam int SQRT_LAT  = ROOT_W;
   localparam int DIV_LAT   = QUO_W;
   localparam int NORM_LAT  = 4 + SQRT_LAT + 2 + DIV_LAT + 1;

   localparam logic [SCALE_W-1:0] ALONG_RESET  = SCALE_W'(37812);
   localparam logic [SCALE_W-1:0] ACROSS_RESET = SCALE_W'(51101);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NV_W-1:0]    nvec_type;
   typedef logic signed [UNIT_W-1:0]  unit_type;

   typedef enum logic {
      CSR_ALONG  = 1'b0,
      CSR_ACROSS = 1'b1
   } csr_index_type;

   // Per-item side data that rides beside the square root pipeline.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [K_W-1:0]        k;
      logic                  zero;
   } nside_type;

   // Sign and zero-length flag that ride beside the dividers.
   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } dside_type;

endpackage

// File: rtl/hpb_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module hpb_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [hpb_pkg::SUM_W-1:0]    radicand,
   output logic                         out_valid,
   output logic [hpb_pkg::ROOT_W-1:0]   root
);
   import hpb_pkg::*;

   logic                vld_ff  [SQRT_LAT];
   logic [ROOT_W-1:0]   root_ff [SQRT_LAT];
   logic [SUM_W-1:0]    x_ff    [SQRT_LAT-1];
   logic [SQ_REM_W-1:0] rem_ff  [SQRT_LAT-1];

   genvar j;
   generate
      for (j = 0; j < SQRT_LAT; j++) begin : g_step
         logic                v_prev;
         logic [SUM_W-1:0]    x_prev;
         logic [SQ_REM_W-1:0] rem_prev;
         logic [ROOT_W-1:0]   root_prev;
         logic [SQ_REM_W-1:0] rem_sh;
         logic [SQ_REM_W-1:0] trial;
         logic [SQ_REM_W-1:0] rem_in;
         logic [ROOT_W-1:0]   root_in;

         if (j == 0) begin : g_first
            assign v_prev    = in_valid;
            assign x_prev    = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
         end else begin : g_next
            assign v_prev    = vld_ff[j-1];
            assign x_prev    = x_ff[j-1];
            assign rem_prev  = rem_ff[j-1];
            assign root_prev = root_ff[j-1];
         end

         // Bring down the next pair of radicand bits and try root*4+1.
         assign rem_sh = {rem_prev[SQ_REM_W-3:0], x_prev[SUM_W-1-2*j -: 2]};
         assign trial  = {1'b0, root_prev, 2'b01};

         always_comb begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_prev[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[j] <= 1'b0;
            end else begin
               vld_ff[j] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            root_ff[j] <= root_in;
         end

         if (j < SQRT_LAT-1) begin : g_carry
            always_ff @(posedge clock) begin
               x_ff[j]   <= x_prev;
               rem_ff[j] <= rem_in;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[SQRT_LAT-1];
   assign root      = root_ff[SQRT_LAT-1];

endmodule

// File: rtl/hpb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hpb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [hpb_pkg::DREM_W-1:0]   rem_init,
   input  logic [hpb_pkg::QUO_W-1:0]    numer_low,
   input  logic [hpb_pkg::ROOT_W-1:0]   divisor,
   output logic                         out_valid,
   output logic [hpb_pkg::QUO_W-1:0]    quotient
);
   import hpb_pkg::*;

   logic              vld_ff [DIV_LAT];
   logic [QUO_W-1:0]  q_ff   [DIV_LAT];
   logic [DREM_W-1:0] rem_ff [DIV_LAT-1];
   logic [QUO_W-1:0]  lo_ff  [DIV_LAT-1];
   logic [ROOT_W-1:0] den_ff [DIV_LAT-1];

   genvar j;
   generate
      for (j = 0; j < DIV_LAT; j++) begin : g_step
         logic              v_prev;
         logic [DREM_W-1:0] rem_prev;
         logic [QUO_W-1:0]  lo_prev;
         logic [ROOT_W-1:0] den_prev;
         logic [QUO_W-1:0]  q_prev;
         logic [DREM_W-1:0] rem_sh;
         logic [DREM_W-1:0] rem_in;
         logic [QUO_W-1:0]  q_in;

         if (j == 0) begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = rem_init;
            assign lo_prev  = numer_low;
            assign den_prev = divisor;
            assign q_prev   = '0;
         end else begin : g_next
            assign v_prev   = vld_ff[j-1];
            assign rem_prev = rem_ff[j-1];
            assign lo_prev  = lo_ff[j-1];
            assign den_prev = den_ff[j-1];
            assign q_prev   = q_ff[j-1];
         end

         // The remainder stays below the divisor, so its top bit is free.
         assign rem_sh = {rem_prev[DREM_W-2:0], lo_prev[QUO_W-1-j]};

         always_comb begin
            if (rem_sh >= {1'b0, den_prev}) begin
               rem_in = rem_sh - {1'b0, den_prev};
               q_in   = {q_prev[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_prev[QUO_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[j] <= 1'b0;
            end else begin
               vld_ff[j] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            q_ff[j] <= q_in;
         end

         if (j < DIV_LAT-1) begin : g_carry
            always_ff @(posedge clock) begin
               rem_ff[j] <= rem_in;
               lo_ff[j]  <= lo_prev;
               den_ff[j] <= den_prev;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[DIV_LAT-1];
   assign quotient  = q_ff[DIV_LAT-1];

endmodule

// File: rtl/hpb_norm.sv
// Vector normalizer: squared length, square root, three rounded divisions.
module hpb_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  hpb_pkg::nvec_type  vec [3],
   output logic               out_valid,
   output logic               out_zero,
   output hpb_pkg::unit_type  unit [3]
);
   import hpb_pkg::*;

   logic                  vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff, vld7_ff;
   logic [2:0][MAG_W-1:0] mag1_ff, mag2_ff, mag3_ff;
   logic [2:0]            neg1_ff, neg2_ff, neg3_ff;
   logic [SQ_W-1:0]       sq2_ff [3];
   logic [SUM_W-1:0]      sum3_ff;
   logic [SUM_W-1:0]      sn4_ff;
   nside_type             side4_ff;
   nside_type             side_dly_ff [SQRT_LAT];
   logic [K_W-1:0]        k_val;
   logic                  sqrt_vld;
   logic [ROOT_W-1:0]     sqrt_root;
   logic [NUM_W-1:0]      sh5_ff [3];
   logic [ROOT_W-1:0]     len5_ff, len6_ff;
   dside_type             dside5_ff, dside6_ff;
   dside_type             dside_dly_ff [DIV_LAT];
   logic [NUM_W-1:0]      numer [3];
   logic [DREM_W-1:0]     hi6_ff [3];
   logic [QUO_W-1:0]      lo6_ff [3];
   logic [2:0]            div_vld;
   logic [QUO_W-1:0]      quo [3];
   logic                  zero7_ff;
   unit_type              unit7_ff [3];

   // Shift count: half the leading zeros, so that the scaled squared length is at least 2^60.
   always_comb begin
      k_val = '0;
      for (int p = 0; p < SUM_W/2; p++) begin
         if (sum3_ff[2*p +: 2] != 2'b00) begin
            k_val = K_W'(SUM_W/2 - 1 - p);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         numer[c] = sh5_ff[c] + NUM_W'(len5_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= sqrt_vld;
         vld6_ff <= vld5_ff;
         vld7_ff <= &div_vld;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         neg1_ff[c] <= vec[c][NV_W-1];
         mag1_ff[c] <= vec[c][NV_W-1] ? MAG_W'(-vec[c]) : MAG_W'(vec[c]);
         sq2_ff[c]  <= mag1_ff[c] * mag1_ff[c];
      end
      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      sum3_ff <= SUM_W'(sq2_ff[0]) + SUM_W'(sq2_ff[1]) + SUM_W'(sq2_ff[2]);
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
      sn4_ff        <= sum3_ff << {k_val, 1'b0};
      side4_ff.mag  <= mag3_ff;
      side4_ff.neg  <= neg3_ff;
      side4_ff.k    <= k_val;
      side4_ff.zero <= (sum3_ff == '0);
      side_dly_ff[0] <= side4_ff;
      for (int i = 1; i < SQRT_LAT; i++) begin
         side_dly_ff[i] <= side_dly_ff[i-1];
      end
      for (int c = 0; c < 3; c++) begin
         sh5_ff[c] <= NUM_W'(side_dly_ff[SQRT_LAT-1].mag[c])
                      << (SH_W'(UNIT_BITS) + SH_W'(side_dly_ff[SQRT_LAT-1].k));
         hi6_ff[c] <= numer[c][QUO_W +: DREM_W];
         lo6_ff[c] <= numer[c][QUO_W-1:0];
      end
      len5_ff        <= sqrt_root;
      dside5_ff.neg  <= side_dly_ff[SQRT_LAT-1].neg;
      dside5_ff.zero <= side_dly_ff[SQRT_LAT-1].zero;
      len6_ff        <= len5_ff;
      dside6_ff      <= dside5_ff;
      dside_dly_ff[0] <= dside6_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         dside_dly_ff[i] <= dside_dly_ff[i-1];
      end
      for (int c = 0; c < 3; c++) begin
         unit7_ff[c] <= dside_dly_ff[DIV_LAT-1].neg[c] ? -$signed({1'b0, quo[c]})
                                                         : $signed({1'b0, quo[c]});
      end
      zero7_ff <= dside_dly_ff[DIV_LAT-1].zero;
   end

   hpb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld4_ff),
      .radicand  (sn4_ff),
      .out_valid (sqrt_vld),
      .root      (sqrt_root)
   );

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_lane
         hpb_div u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (vld6_ff),
            .rem_init  (hi6_ff[c]),
            .numer_low (lo6_ff[c]),
            .divisor   (len6_ff),
            .out_valid (div_vld[c]),
            .quotient  (quo[c])
         );
      end
   endgenerate

   assign out_valid = vld7_ff;
   assign out_zero  = zero7_ff;
   assign unit      = unit7_ff;

endmodule

// File: rtl/hydrogen_pair_by_bisection_core.sv
// Top level: places two hydrogens on a central atom from its two neighbors.
//
//   channel   ports                         handshake
//   request   req_first/center/third_x/y/z  start && !busy
//   response  rsp_minus/plus_x/y/z, degen.  rsp_valid, one cycle
//   csr       csr_index, csr_wdata          csr_we
//
// The path is one input stage, two normalizers (a 31-stage square root and a
// 29-stage divider dominate each), one summing stage and five stages of cross
// product, scaling and rounding. One item enters per clock.
// busy stays low; synchronous reset empties the pipeline and loads the scales.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module hydrogen_pair_by_bisection_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hpb_pkg::coord_type            req_first_x,
   input  hpb_pkg::coord_type            req_first_y,
   input  hpb_pkg::coord_type            req_first_z,
   input  hpb_pkg::coord_type            req_center_x,
   input  hpb_pkg::coord_type            req_center_y,
   input  hpb_pkg::coord_type            req_center_z,
   input  hpb_pkg::coord_type            req_third_x,
   input  hpb_pkg::coord_type            req_third_y,
   input  hpb_pkg::coord_type            req_third_z,
   output logic                          rsp_valid,
   output hpb_pkg::coord_type            rsp_minus_x,
   output hpb_pkg::coord_type            rsp_minus_y,
   output hpb_pkg::coord_type            rsp_minus_z,
   output hpb_pkg::coord_type            rsp_plus_x,
   output hpb_pkg::coord_type            rsp_plus_y,
   output hpb_pkg::coord_type            rsp_plus_z,
   output logic                          rsp_degenerate,
   input  logic                          csr_we,
   input  hpb_pkg::csr_index_type        csr_index,
   input  logic [hpb_pkg::SCALE_W-1:0]   csr_wdata
);
   import hpb_pkg::*;

   function automatic coord_type finish(input logic signed [TOT_W-1:0] t);
      logic signed [TOT_W-1:0]         rnd;
      logic signed [TOT_W-UNIT_BITS-1:0] r;
      rnd = t + (TOT_W'(1) <<< (UNIT_BITS-1));
      r   = (TOT_W-UNIT_BITS)'(rnd >>> UNIT_BITS);
      if (r > (TOT_W-UNIT_BITS)'(2**(COORD_W-1) - 1)) begin
         return coord_type'(2**(COORD_W-1) - 1);
      end else if (r < -(TOT_W-UNIT_BITS)'(2**(COORD_W-1))) begin
         return coord_type'(-(2**(COORD_W-1)));
      end
      return coord_type'(r);
   endfunction

   logic [SCALE_W-1:0] along_ff, across_ff;

   coord_type   in_a [3], in_b [3], in_c [3];
   logic        vld0_ff;
   nvec_type    d1_ff [3], d3_ff [3], e_ff [3];
   coord_type   b0_ff [3];
   coord_type   b_dly_ff [NORM_LAT][3];

   logic        n1_vld, n3_vld, ne_vld, nb_vld;
   logic        n1_zero, n3_zero, ne_zero, nb_zero;
   unit_type    u1 [3], u3 [3], ue [3], ub [3];

   logic        vld1_ff, deg1_ff;
   nvec_type    sum1_ff [3];
   unit_type    ue1_ff [3];
   coord_type   b1_ff [3];
   unit_type    ue_dly_ff [NORM_LAT][3];
   coord_type   b2_dly_ff [NORM_LAT][3];
   logic        deg_dly_ff [NORM_LAT];

   logic        vld2_ff, deg2_ff;
   logic signed [PROD_W-1:0] prod2_ff [6];
   unit_type    ub2_ff [3];
   coord_type   b2_ff [3];

   logic        vld3_ff, deg3_ff;
   logic signed [CR_W-1:0]   cr [3];
   logic signed [P_W-1:0]    p3_ff [3];
   logic signed [ALONG_W-1:0] along3_ff [3];
   coord_type   b3_ff [3];

   logic        vld4_ff, deg4_ff;
   logic signed [BASE_W-1:0]   base4_ff [3];
   logic signed [ACROSS_W-1:0] across4_ff [3];

   logic        vld5_ff, deg5_ff;
   logic signed [TOT_W-1:0] tm5_ff [3], tp5_ff [3];

   logic        out_vld_ff, out_deg_ff;
   coord_type   out_m_ff [3], out_p_ff [3];

   assign busy = 1'b0;

   assign in_a = '{req_first_x, req_first_y, req_first_z};
   assign in_b = '{req_center_x, req_center_y, req_center_z};
   assign in_c = '{req_third_x, req_third_y, req_third_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         along_ff  <= ALONG_RESET;
         across_ff <= ACROSS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALONG: begin
               along_ff <= csr_wdata;
            end
            CSR_ACROSS: begin
               across_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff    <= 1'b0;
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vld4_ff    <= 1'b0;
         vld5_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld0_ff    <= start && !busy;
         vld1_ff    <= n1_vld && n3_vld && ne_vld;
         vld2_ff    <= nb_vld;
         vld3_ff    <= vld2_ff;
         vld4_ff    <= vld3_ff;
         vld5_ff    <= vld4_ff;
         out_vld_ff <= vld5_ff;
      end
   end

   always_comb begin
      cr[0] = CR_W'(prod2_ff[0]) - CR_W'(prod2_ff[1]);
      cr[1] = CR_W'(prod2_ff[2]) - CR_W'(prod2_ff[3]);
      cr[2] = CR_W'(prod2_ff[4]) - CR_W'(prod2_ff[5]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d1_ff[i] <= NV_W'(in_b[i]) - NV_W'(in_a[i]);
         d3_ff[i] <= NV_W'(in_b[i]) - NV_W'(in_c[i]);
         e_ff[i]  <= NV_W'(in_c[i]) - NV_W'(in_a[i]);
         b0_ff[i] <= in_b[i];
      end
      b_dly_ff[0] <= b0_ff;
      for (int s = 1; s < NORM_LAT; s++) begin
         b_dly_ff[s] <= b_dly_ff[s-1];
      end

      // Bisector sum of the two unit vectors toward the center.
      for (int i = 0; i < 3; i++) begin
         sum1_ff[i] <= NV_W'(u1[i]) + NV_W'(u3[i]);
      end
      ue1_ff  <= ue;
      b1_ff   <= b_dly_ff[NORM_LAT-1];
      deg1_ff <= n1_zero || n3_zero || ne_zero;

      ue_dly_ff[0]  <= ue1_ff;
      b2_dly_ff[0]  <= b1_ff;
      deg_dly_ff[0] <= deg1_ff;
      for (int s = 1; s < NORM_LAT; s++) begin
         ue_dly_ff[s]  <= ue_dly_ff[s-1];
         b2_dly_ff[s]  <= b2_dly_ff[s-1];
         deg_dly_ff[s] <= deg_dly_ff[s-1];
      end

      prod2_ff[0] <= ue_dly_ff[NORM_LAT-1][1] * ub[2];
      prod2_ff[1] <= ue_dly_ff[NORM_LAT-1][2] * ub[1];
      prod2_ff[2] <= ue_dly_ff[NORM_LAT-1][2] * ub[0];
      prod2_ff[3] <= ue_dly_ff[NORM_LAT-1][0] * ub[2];
      prod2_ff[4] <= ue_dly_ff[NORM_LAT-1][0] * ub[1];
      prod2_ff[5] <= ue_dly_ff[NORM_LAT-1][1] * ub[0];
      ub2_ff  <= ub;
      b2_ff   <= b2_dly_ff[NORM_LAT-1];
      deg2_ff <= deg_dly_ff[NORM_LAT-1] || nb_zero;

      for (int i = 0; i < 3; i++) begin
         p3_ff[i] <= P_W'((cr[i] + (CR_W'(1) <<< (UNIT_BITS-1))) >>> UNIT_BITS);
         along3_ff[i] <= $signed({1'b0, along_ff}) * ub2_ff[i];
      end
      b3_ff   <= b2_ff;
      deg3_ff <= deg2_ff;

      for (int i = 0; i < 3; i++) begin
         base4_ff[i]   <= (BASE_W'(b3_ff[i]) <<< UNIT_BITS) + BASE_W'(along3_ff[i]);
         across4_ff[i] <= $signed({1'b0, across_ff}) * p3_ff[i];
      end
      deg4_ff <= deg3_ff;

      for (int i = 0; i < 3; i++) begin
         tm5_ff[i] <= TOT_W'(base4_ff[i]) - TOT_W'(across4_ff[i]);
         tp5_ff[i] <= TOT_W'(base4_ff[i]) + TOT_W'(across4_ff[i]);
      end
      deg5_ff <= deg4_ff;

      // A zero-length vector anywhere clears all coordinates of the item.
      for (int i = 0; i < 3; i++) begin
         out_m_ff[i] <= deg5_ff ? coord_type'(0) : finish(tm5_ff[i]);
         out_p_ff[i] <= deg5_ff ? coord_type'(0) : finish(tp5_ff[i]);
      end
      out_deg_ff <= deg5_ff;
   end

   hpb_norm u_norm_first (
      .clock (clock), .reset (reset), .in_valid (vld0_ff), .vec (d1_ff),
      .out_valid (n1_vld), .out_zero (n1_zero), .unit (u1)
   );

   hpb_norm u_norm_third (
      .clock (clock), .reset (reset), .in_valid (vld0_ff), .vec (d3_ff),
      .out_valid (n3_vld), .out_zero (n3_zero), .unit (u3)
   );

   hpb_norm u_norm_edge (
      .clock (clock), .reset (reset), .in_valid (vld0_ff), .vec (e_ff),
      .out_valid (ne_vld), .out_zero (ne_zero), .unit (ue)
   );

   hpb_norm u_norm_bisect (
      .clock (clock), .reset (reset), .in_valid (vld1_ff), .vec (sum1_ff),
      .out_valid (nb_vld), .out_zero (nb_zero), .unit (ub)
   );

   assign rsp_valid      = out_vld_ff;
   assign rsp_degenerate = out_deg_ff;
   assign rsp_minus_x    = out_m_ff[0];
   assign rsp_minus_y    = out_m_ff[1];
   assign rsp_minus_z    = out_m_ff[2];
   assign rsp_plus_x     = out_p_ff[0];
   assign rsp_plus_y     = out_p_ff[1];
   assign rsp_plus_z     = out_p_ff[2];

   // A degenerate item carries all-zero coordinates.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_minus_x == 0 && rsp_minus_y == 0 && rsp_minus_z == 0 &&
         rsp_plus_x == 0 && rsp_plus_y == 0 && rsp_plus_z == 0)
      else $error("degenerate item with nonzero coordinates");

   // A bisector from good inputs never exceeds unit length per component.
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      nb_vld && !nb_zero && !deg_dly_ff[NORM_LAT-1] |->
         ub[0] <= 30'sd268435457 && ub[0] >= -30'sd268435457 &&
         ub[1] <= 30'sd268435457 && ub[1] >= -30'sd268435457 &&
         ub[2] <= 30'sd268435457 && ub[2] >= -30'sd268435457)
      else $error("bisector component out of unit range");

   // The response strobe follows valid items in stages vld4_ff and vld5_ff.
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld5_ff) && $past(vld4_ff, 2))
      else $error("response without a matching pipeline item");

endmodule

// File: tb/tb_hydrogen_pair_by_bisection_core.sv
// Self-checking testbench for the hydrogen pair placement core.
`timescale 1ns / 1ps

module tb_hydrogen_pair_by_bisection_core;
   import hpb_pkg::*;

   typedef longint vec3_type [3];

   typedef struct {
      coord_type first [3];
      coord_type center [3];
      coord_type third [3];
   } triple_type;

   typedef struct {
      coord_type minus [3];
      coord_type plus [3];
      logic      degenerate;
   } hydrogen_pair_type;

   class hydrogen_scoreboard;
      hydrogen_pair_type pending [$];
      logic [SCALE_W-1:0] along;
      logic [SCALE_W-1:0] across;
      int errors;
      int checked;
      int degenerate_seen;

      function new();
         along = ALONG_RESET;
         across = ACROSS_RESET;
         errors = 0;
         checked = 0;
         degenerate_seen = 0;
      endfunction

      function void set_scale(csr_index_type idx, logic [SCALE_W-1:0] value);
         if (idx == CSR_ALONG) begin
            along = value;
         end else begin
            across = value;
         end
      endfunction

      function longint unsigned int_root(longint unsigned x);
         longint unsigned r, bit_val;
         r = 0;
         bit_val = 64'd1 << 62;
         while (bit_val > x) bit_val = bit_val >> 2;
         while (bit_val != 0) begin
            if (x >= r + bit_val) begin
               x = x - (r + bit_val);
               r = (r >> 1) + bit_val;
            end else begin
               r = r >> 1;
            end
            bit_val = bit_val >> 2;
         end
         return r;
      endfunction

      // Scales v to unit length with UNIT_BITS fraction bits; 0 on zero length.
      function bit unitize(input vec3_type v, output vec3_type u);
         longint unsigned s, len, m, q;
         int k;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            s = s + m * m;
         end
         for (int i = 0; i < 3; i++) u[i] = 0;
         if (s == 0) return 1'b0;
         k = 0;
         while (s < (64'd1 << 60)) begin
            s = s << 2;
            k++;
         end
         len = int_root(s);
         for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            q = ((m << (UNIT_BITS + k)) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
         return 1'b1;
      endfunction

      function coord_type round_saturate(longint t);
         longint r;
         r = (t + (64'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
         if (r > longint'((1 << (COORD_W - 1)) - 1)) r = (1 << (COORD_W - 1)) - 1;
         if (r < -longint'(1 << (COORD_W - 1))) r = -longint'(1 << (COORD_W - 1));
         return coord_type'(r);
      endfunction

      function void note_triple(triple_type t);
         hydrogen_pair_type h;
         vec3_type d1, d3, e, sum, u1, u3, ue, ub, cr;
         longint p, base, term;
         bit ok;
         for (int i = 0; i < 3; i++) begin
            d1[i] = longint'(t.center[i]) - longint'(t.first[i]);
            d3[i] = longint'(t.center[i]) - longint'(t.third[i]);
            e[i] = longint'(t.third[i]) - longint'(t.first[i]);
         end
         ok = unitize(d1, u1);
         if (ok) ok = unitize(d3, u3);
         if (ok) ok = unitize(e, ue);
         if (ok) begin
            for (int i = 0; i < 3; i++) sum[i] = u1[i] + u3[i];
            ok = unitize(sum, ub);
         end
         h.degenerate = !ok;
         for (int i = 0; i < 3; i++) begin
            h.minus[i] = '0;
            h.plus[i] = '0;
         end
         if (ok) begin
            cr[0] = ue[1] * ub[2] - ue[2] * ub[1];
            cr[1] = ue[2] * ub[0] - ue[0] * ub[2];
            cr[2] = ue[0] * ub[1] - ue[1] * ub[0];
            for (int i = 0; i < 3; i++) begin
               p = (cr[i] + (64'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
               base = (longint'(t.center[i]) <<< UNIT_BITS) + longint'(along) * ub[i];
               term = longint'(across) * p;
               h.minus[i] = round_saturate(base - term);
               h.plus[i] = round_saturate(base + term);
            end
         end
         pending.push_back(h);
      endfunction

      task report(string what, longint got, longint want);
         $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_pair(hydrogen_pair_type got);
         hydrogen_pair_type want;
         if (pending.size() == 0) begin
            report("items outstanding at a result", 0, 1);
         end else begin
            want = pending.pop_front();
            checked++;
            if (want.degenerate) degenerate_seen++;
            for (int i = 0; i < 3; i++) begin
               if (got.minus[i] !== want.minus[i])
                  report($sformatf("minus[%0d]", i), got.minus[i], want.minus[i]);
               if (got.plus[i] !== want.plus[i])
                  report($sformatf("plus[%0d]", i), got.plus[i], want.plus[i]);
            end
            if (got.degenerate !== want.degenerate)
               report("degenerate", got.degenerate, want.degenerate);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   coord_type req_first_x, req_first_y, req_first_z;
   coord_type req_center_x, req_center_y, req_center_z;
   coord_type req_third_x, req_third_y, req_third_z;
   logic rsp_valid;
   coord_type rsp_minus_x, rsp_minus_y, rsp_minus_z;
   coord_type rsp_plus_x, rsp_plus_y, rsp_plus_z;
   logic rsp_degenerate;
   logic csr_we;
   csr_index_type csr_index;
   logic [SCALE_W-1:0] csr_wdata;

   hydrogen_scoreboard sb = new();
   int idle_max;
   int sent;

   hydrogen_pair_by_bisection_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      hydrogen_pair_type got;
      if (!reset && rsp_valid) begin
         got.minus[0] = rsp_minus_x;
         got.minus[1] = rsp_minus_y;
         got.minus[2] = rsp_minus_z;
         got.plus[0] = rsp_plus_x;
         got.plus[1] = rsp_plus_y;
         got.plus[2] = rsp_plus_z;
         got.degenerate = rsp_degenerate;
         sb.check_pair(got);
      end
   end

   task write_scale(csr_index_type idx, logic [SCALE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_scale(idx, value);
   endtask

   task wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   // Holds one item on the request ports until the core takes it.
   task send_triple(triple_type t);
      int gap;
      gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      {req_first_x, req_first_y, req_first_z} <= {t.first[0], t.first[1], t.first[2]};
      {req_center_x, req_center_y, req_center_z} <= {t.center[0], t.center[1], t.center[2]};
      {req_third_x, req_third_y, req_third_z} <= {t.third[0], t.third[1], t.third[2]};
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_triple(t);
      sent++;
   endtask

   task stop_sending();
      @(negedge clock);
      start <= 1'b0;
   endtask

   function coord_type full_random();
      return coord_type'($urandom);
   endfunction

   // A neighbor about one bond length away in a random direction.
   function coord_type near(coord_type c);
      return coord_type'(longint'(c) + longint'($urandom_range(0, 200000)) - 100000);
   endfunction

   function triple_type random_triple();
      triple_type t;
      int mode;
      mode = $urandom_range(0, 19);
      for (int i = 0; i < 3; i++) begin
         t.center[i] = (mode < 14) ? coord_type'(longint'($urandom_range(0, 1 << 26)) - (1 << 25))
                                   : full_random();
         t.first[i] = (mode < 14) ? near(t.center[i]) : full_random();
         t.third[i] = (mode < 14) ? near(t.center[i]) : full_random();
      end
      case (mode)
         14: t.first = t.center;
         15: t.third = t.center;
         16: t.third = t.first;
         17: begin
            // Neighbors mirrored through the center, so the bisector vanishes.
            for (int i = 0; i < 3; i++) begin
               t.center[i] = coord_type'(longint'($urandom_range(0, 1 << 24)) - (1 << 23));
               t.third[i] = coord_type'(2 * longint'(t.center[i]) - longint'(near(t.center[i])));
               t.first[i] = coord_type'(2 * longint'(t.center[i]) - longint'(t.third[i]));
            end
         end
         default: ;
      endcase
      return t;
   endfunction

   function triple_type make_triple(coord_type a, coord_type b, coord_type c);
      triple_type t;
      for (int i = 0; i < 3; i++) begin
         t.first[i] = a;
         t.center[i] = b;
         t.third[i] = c;
      end
      return t;
   endfunction

   task run_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         send_triple(random_triple());
      end
      stop_sending();
   endtask

   initial begin
      triple_type t;
      coord_type cmax, cmin;
      cmax = coord_type'((1 << (COORD_W - 1)) - 1);
      cmin = coord_type'(-(1 << (COORD_W - 1)));
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ALONG;
      csr_wdata = '0;
      {req_first_x, req_first_y, req_first_z} = '0;
      {req_center_x, req_center_y, req_center_z} = '0;
      {req_third_x, req_third_y, req_third_z} = '0;
      sent = 0;
      idle_max = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset scales.
      send_triple(make_triple(cmin, cmax, cmin + 5));
      send_triple(make_triple(cmax, cmin, cmax - 7));
      send_triple(make_triple(0, 0, 0));
      send_triple(make_triple(100, 100, 5000));
      send_triple(make_triple(100, 5000, 5000));
      send_triple(make_triple(7000, -300, 7000));
      send_triple(make_triple(-65536, 0, 65536));
      t = make_triple(cmax - 70000, cmax, cmax - 30000);
      t.first[1] = cmax - 90000;
      send_triple(t);
      t = make_triple(cmin + 70000, cmin, cmin + 30000);
      t.third[2] = cmin + 100000;
      send_triple(t);
      t = make_triple(0, 98304, 0);
      t.third[0] = 98304;
      t.first[1] = 180000;
      send_triple(t);
      t = make_triple(cmin, cmax, cmax);
      t.third[0] = cmin;
      send_triple(t);
      for (int n = 0; n < 8; n++) send_triple(random_triple());
      stop_sending();
      run_random(200);
      wait_drained();

      write_scale(CSR_ALONG, '0);
      write_scale(CSR_ACROSS, '0);
      run_random(200);
      wait_drained();

      write_scale(CSR_ALONG, '1);
      write_scale(CSR_ACROSS, '1);
      run_random(250);
      wait_drained();

      write_scale(CSR_ALONG, '0);
      run_random(100);
      // The sender holds off here until every pending result has come.
      while (sb.pending.size() != 0) @(negedge clock);
      run_random(100);
      wait_drained();

      write_scale(CSR_ALONG, SCALE_W'($urandom));
      write_scale(CSR_ACROSS, SCALE_W'($urandom));
      run_random(330);
      wait_drained();

      $display("sent %0d atom triples over five scale settings, %0d results checked",
               sent, sb.checked);
      $display("%0d results were degenerate, %0d mismatches", sb.degenerate_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
